/* rtl/masked_byte_pattern_scanner_defines.svh */
// ----------------------------------------------------------------------------
// Masked byte pattern scanner: assertion macros
// Shared property macros, which are empty when the code is synthesised.
// ----------------------------------------------------------------------------
`ifndef MASKED_BYTE_PATTERN_SCANNER_DEFINES_SVH
`define MASKED_BYTE_PATTERN_SCANNER_DEFINES_SVH

`ifndef SYNTHESIS
`define MBPS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define MBPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MBPS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define MBPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

/* rtl/mbps_pkg.sv */
// ----------------------------------------------------------------------------
// Masked byte pattern scanner: package
// Constants, request and result types and register indices.
// ----------------------------------------------------------------------------
package mbps_pkg;

    localparam int MAX_PATTERN_BYTES = 16;
    localparam int OFFSET_BITS       = 32;
    localparam int RESULT_OFFSET_W   = 32;
    localparam int LEN_W             = 5;
    localparam int CFG_DATA_W        = 64;
    localparam int CFG_IDX_W         = 2;
    localparam int PAT_IDX_W         = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW  = 2'd0,
        CFG_PATTERN_HIGH = 2'd1,
        CFG_WILDCARD     = 2'd2,
        CFG_LENGTH       = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       region_end;
    } t_req;

    typedef struct packed {
        logic                       found;
        logic [RESULT_OFFSET_W-1:0] match_offset;
    } t_res;

endpackage

/* rtl/mbps_cell.sv */
// ----------------------------------------------------------------------------
// Masked byte pattern scanner: window cell
// Holds one byte of the window, passes it on and compares its incoming byte.
// ----------------------------------------------------------------------------
module mbps_cell
    import mbps_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_shift,
    input  logic       i_clear,
    input  logic [7:0] i_byte,
    input  logic [7:0] i_pat,
    input  logic       i_wild,
    input  logic       i_active,
    output logic [7:0] o_byte,
    output logic       o_hit
);

    logic [7:0] r_byte;
    logic [7:0] n_byte;

    always_comb begin
        n_byte = r_byte;
        if (i_clear) begin
            n_byte = 8'd0;
        end else if (i_shift) begin
            n_byte = i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= 8'd0;
        end else begin
            r_byte <= n_byte;
        end
    end

    assign o_byte = r_byte;
    assign o_hit  = !i_active || i_wild || (i_byte == i_pat);

endmodule

/* rtl/mbps_skid.sv */
// ----------------------------------------------------------------------------
// Masked byte pattern scanner: result buffer
// Output register with a skid stage, so that requests keep flowing.
// ----------------------------------------------------------------------------
module mbps_skid
    import mbps_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_res i_res,
    output logic o_full,
    output logic o_valid,
    output t_res o_res,
    input  logic i_stall
);

    logic r_out_valid;
    logic n_out_valid;
    t_res r_out;
    t_res n_out;
    logic r_skid_valid;
    logic n_skid_valid;
    t_res r_skid;
    t_res n_skid;
    logic w_drain;

    assign w_drain = r_out_valid && !i_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (w_drain || !r_out_valid) begin
                n_out_valid  = 1'b1;
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (i_push) begin
            if (w_drain || !r_out_valid) begin
                n_out_valid = 1'b1;
                n_out       = i_res;
            end else begin
                n_skid_valid = 1'b1;
                n_skid       = i_res;
            end
        end else if (w_drain) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule

/* rtl/masked_byte_pattern_scanner.sv */
// ----------------------------------------------------------------------------
// Masked byte pattern scanner: top level
// Finds the first place in a byte region where a masked pattern matches.
// ----------------------------------------------------------------------------
// Bytes of a region arrive on the request channel (i_valid, o_stall, i_req),
// the last one flagged by region_end. Results leave on o_valid, i_stall and
// o_res: one found result at the first full match, carrying the offset of its
// first byte, or one not-found result at the end of a region without a match.
// The pattern, wildcard mask and length are written through the plain write
// port; the user must do this only while the block is idle (not enforced).
// A request is taken in every cycle in which o_stall is low; a row of sixteen
// window cells compares the new byte and the stored bytes against the pattern
// in that same cycle. A result is registered before it appears on o_valid.
// When the receiver stalls, one further result is held in a skid stage, and
// o_stall rises only once that stage is occupied.
// Reset clears the window, byte count and match flag and sets the pattern
// length to one; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "masked_byte_pattern_scanner_defines.svh"

module masked_byte_pattern_scanner
    import mbps_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  t_req                          i_req,
    output logic                          o_valid,
    input  logic                          i_stall,
    output t_res                          o_res
);

    logic [63:0]                    r_pat_low;
    logic [63:0]                    r_pat_high;
    logic [15:0]                    r_wild;
    logic [LEN_W-1:0]               r_len;
    logic [OFFSET_BITS-1:0]         r_count;
    logic [OFFSET_BITS-1:0]         n_count;
    logic                           r_done;
    logic                           n_done;

    logic                           w_fire;
    logic                           w_full;
    logic [LEN_W-1:0]               w_len;
    logic [127:0]                   w_pat_all;
    logic [7:0]                     w_pat [MAX_PATTERN_BYTES];
    logic [7:0]                     w_chain [MAX_PATTERN_BYTES+1];
    logic [MAX_PATTERN_BYTES-1:0]   w_hit;
    logic [OFFSET_BITS-1:0]         w_cnt_inc;
    logic [OFFSET_BITS-1:0]         w_offset;
    logic                           w_match;
    logic                           w_push;
    t_res                           w_res;

    assign w_fire    = i_valid && !o_stall;
    assign o_stall   = w_full;
    assign w_pat_all = {r_pat_high, r_pat_low};

    always_comb begin
        w_len = r_len;
        if (r_len == '0) begin
            w_len = LEN_W'(1);
        end else if (r_len > LEN_W'(MAX_PATTERN_BYTES)) begin
            w_len = LEN_W'(MAX_PATTERN_BYTES);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_wild     <= '0;
            r_len      <= LEN_W'(1);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PATTERN_LOW: begin
                    r_pat_low <= i_cfg_data[63:0];
                end
                CFG_PATTERN_HIGH: begin
                    r_pat_high <= i_cfg_data[63:0];
                end
                CFG_WILDCARD: begin
                    r_wild <= i_cfg_data[15:0];
                end
                CFG_LENGTH: begin
                    r_len <= i_cfg_data[LEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign w_chain[0] = i_req.data_byte;

    for (genvar p = 0; p < MAX_PATTERN_BYTES; p++) begin : g_cell
        logic [LEN_W-1:0]     w_k;
        logic [PAT_IDX_W-1:0] w_idx;

        assign w_pat[p] = w_pat_all[8*p +: 8];
        assign w_k      = w_len - LEN_W'(p) - LEN_W'(1);
        assign w_idx    = w_k[PAT_IDX_W-1:0];

        mbps_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_shift  (w_fire),
            .i_clear  (w_fire && i_req.region_end),
            .i_byte   (w_chain[p]),
            .i_pat    (w_pat[w_idx]),
            .i_wild   (r_wild[w_idx]),
            .i_active (LEN_W'(p) < w_len),
            .o_byte   (w_chain[p+1]),
            .o_hit    (w_hit[p])
        );
    end

    assign w_cnt_inc = (r_count == '1) ? r_count : r_count + OFFSET_BITS'(1);
    assign w_offset  = w_cnt_inc - OFFSET_BITS'(w_len);
    assign w_match   = !r_done && (w_cnt_inc >= OFFSET_BITS'(w_len)) && (&w_hit);

    always_comb begin
        w_push             = 1'b0;
        w_res.found        = 1'b0;
        w_res.match_offset = '0;
        if (w_fire) begin
            if (w_match) begin
                w_push             = 1'b1;
                w_res.found        = 1'b1;
                w_res.match_offset = RESULT_OFFSET_W'(w_offset);
            end else if (i_req.region_end && !r_done) begin
                w_push = 1'b1;
            end
        end
    end

    always_comb begin
        n_count = r_count;
        n_done  = r_done;
        if (w_fire) begin
            if (i_req.region_end) begin
                n_count = '0;
                n_done  = 1'b0;
            end else begin
                n_count = w_cnt_inc;
                n_done  = r_done || w_match;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    mbps_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_res   (w_res),
        .o_full  (w_full),
        .o_valid (o_valid),
        .o_res   (o_res),
        .i_stall (i_stall)
    );

    `MBPS_ASSERT_IMPL(a_stall_needs_output, i_clk, i_rst_n, o_stall, o_valid, "skid full with empty output")
    `MBPS_ASSERT_NEXT(a_region_end_clears, i_clk, i_rst_n, w_fire && i_req.region_end, (r_count == '0) && !r_done, "region state not cleared")
    `MBPS_ASSERT_NEXT(a_match_sets_done, i_clk, i_rst_n, w_fire && w_match && !i_req.region_end, r_done, "match did not set done")
    `MBPS_ASSERT_IMPL(a_not_found_zero, i_clk, i_rst_n, o_valid && !o_res.found, o_res.match_offset == '0, "not-found result with offset")

endmodule
